// ===== rtl/rational_arithmetic_unit_defines.svh =====
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Implication checked at each rising edge, disabled during reset.
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rau_pkg.sv =====
`default_nettype none
package rau_pkg;

  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned ProdWidth = 64;

  typedef enum logic [3:0] {
    CmdNorm = 4'd0,
    CmdNeg  = 4'd1,
    CmdAdd  = 4'd2,
    CmdSub  = 4'd3,
    CmdMul  = 4'd4,
    CmdDiv  = 4'd5,
    CmdEq   = 4'd6,
    CmdNe   = 4'd7,
    CmdLt   = 4'd8,
    CmdGt   = 4'd9,
    CmdLe   = 4'd10,
    CmdGe   = 4'd11
  } cmd_e;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StZeroDen = 2'd1,
    StDivZero = 2'd2,
    StOvf     = 2'd3
  } status_e;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture operands
    logic mul_a;    // first product pair
    logic mul_b;    // second product pair
    logic form;     // form n, d
    logic gcd_init; // load gcd operands
    logic mod_init; // start one remainder
    logic mod_step; // one restoring-division bit
    logic mod_done; // swap after remainder
    logic div_init; // start dividing by the gcd
    logic div_step; // one quotient bit
    logic finish;   // build result register
  } rau_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic early;    // result known without reduction
    logic y_zero;   // gcd second operand is zero
    logic cnt_zero; // bit counter exhausted
  } rau_stat_t;

endpackage
`default_nettype wire

// ===== rtl/rational_arithmetic_unit.sv =====
// Channel | Signals                                   | Direction
// input   | in_valid_i/in_ready_o, command_i, a_*, b_* | into block
// output  | out_valid_o/out_ready_i, res_*, truth, status | out of block
// One beat is handled at a time. Comparisons and early-status cases go from
// load through both multiply steps, form and check straight to finish;
// reduced results take the Euclidean gcd on a shared restoring divider and
// then divide numerator and denominator by it. rst_ni clears the controller
// asynchronously. A result waits in its register until taken; no input
// beat is taken then.
`default_nettype none
module rational_arithmetic_unit
  import rau_pkg::*;
#(
  parameter int unsigned ValueWidth = ValueWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [3:0]  command_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [30:0] b_den_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [31:0] res_num_o,
  output logic      [30:0] res_den_o,
  output logic             truth_o,
  output logic      [1:0]  status_o
);

  rau_cmd_t  cmd;
  rau_stat_t stat;

  // The controller sequences each beat through multiply and, where reduction is needed, gcd and divide.
  rau_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .stat_i(stat), .cmd_o(cmd)
  );

  // The datapath holds the operands, products and the shared divider.
  rau_datapath #(.ValueWidth(ValueWidth)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stat_o(stat), .command_i, .a_num_i,
    .a_den_i, .b_num_i, .b_den_i, .res_num_o, .res_den_o, .truth_o, .status_o
  );

endmodule
`default_nettype wire

// ===== rtl/rau_datapath.sv =====
`default_nettype none
module rau_datapath
  import rau_pkg::*;
#(
  parameter int unsigned ValueWidth = ValueWidthDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire rau_cmd_t    cmd_i,
  output rau_stat_t        stat_o,
  input  wire logic [3:0]  command_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [30:0] b_den_i,
  output logic      [31:0] res_num_o,
  output logic      [30:0] res_den_o,
  output logic             truth_o,
  output logic      [1:0]  status_o
);

  localparam int unsigned W = ProdWidth;
  localparam int unsigned CW = $clog2(W + 1);
  localparam logic [W-1:0] Lim = W'(1) << (ValueWidth - 1);

  logic [3:0]  cmd_q;
  logic signed [31:0] an_q, ad_q, bn_q, bd_q;
  logic signed [W-1:0] p0_q, p1_q, n_q, d_q;
  logic [W-1:0] x_q, y_q, r_q, q_q, mn_q, md_q;
  logic [CW-1:0] cnt_q;
  logic neg_q, early_q, phase_q;
  logic [31:0] rn_q;
  logic [30:0] rd_q;
  logic rt_q;
  logic [1:0] rs_q;

  logic signed [31:0] m0a, m0b, m1a, m1b;
  logic signed [W-1:0] nd, dd;
  logic [W-1:0] dvd, dvs, trial_r;
  logic [W:0]   trial;
  logic [W-1:0] mn_v, md_v;

  always_comb begin
    m0a = an_q;
    m0b = bd_q;
    m1a = bn_q;
    m1b = ad_q;
    if (cmd_i.mul_b) begin
      m0a = an_q;
      m0b = bn_q;
      m1a = ad_q;
      m1b = bd_q;
    end
  end

  always_comb begin
    nd = '0;
    dd = '0;
    case (cmd_q)
      CmdNorm: begin nd = W'(an_q); dd = W'(ad_q); end
      CmdNeg:  begin nd = -W'(an_q); dd = W'(ad_q); end
      CmdAdd:  begin nd = p0_q + p1_q; dd = n_q; end
      CmdSub:  begin nd = p0_q - p1_q; dd = n_q; end
      CmdMul:  begin nd = p0_q; dd = p1_q; end
      CmdDiv:  begin nd = p0_q; dd = d_q; end
      default: begin nd = '0; dd = '0; end
    endcase
  end

  // Shared restoring divider: remainder of x by y, or mn/md by gcd.
  assign dvs = cmd_i.div_step ? x_q : y_q;
  assign dvd = q_q;
  assign trial = {r_q, dvd[W-1]} - {1'b0, dvs};
  assign trial_r = trial[W] ? {r_q[W-2:0], dvd[W-1]} : trial[W-1:0];

  assign mn_v = n_q[W-1] ? -n_q : n_q;
  assign md_v = d_q[W-1] ? -d_q : d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q <= '0;
      cnt_q <= '0;
      phase_q <= 1'b0;
      early_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cmd_q <= command_i;
        an_q <= a_num_i;
        ad_q <= a_den_i;
        bn_q <= b_num_i;
        bd_q <= {1'b0, b_den_i};
      end
      if (cmd_i.mul_a) begin
        p0_q <= W'(m0a) * W'(m0b);
        p1_q <= W'(m1a) * W'(m1b);
        d_q  <= W'(ad_q) * W'(bn_q);
      end
      if (cmd_i.mul_b) begin
        // keep cross products for add/sub; den in n_q temporarily
        n_q <= W'(m1a) * W'(m1b);
        if (cmd_q == CmdMul) begin
          p0_q <= W'(m0a) * W'(m0b);
          p1_q <= W'(m1a) * W'(m1b);
        end
      end
      if (cmd_i.form) begin
        n_q <= nd;
        d_q <= dd;
        neg_q <= nd[W-1] ^ dd[W-1];
        early_q <= (cmd_q > CmdDiv) || (cmd_q == CmdDiv && bn_q == 0) || dd == 0 || nd == 0;
      end
      if (cmd_i.gcd_init) begin
        x_q <= mn_v;
        y_q <= md_v;
        mn_q <= mn_v;
        md_q <= md_v;
        phase_q <= 1'b0;
      end
      if (cmd_i.mod_init) begin
        q_q <= x_q;
        r_q <= '0;
        cnt_q <= CW'(W);
      end
      if (cmd_i.div_init) begin
        q_q <= phase_q ? md_q : mn_q;
        r_q <= '0;
        cnt_q <= CW'(W);
      end
      if (cmd_i.mod_step || cmd_i.div_step) begin
        r_q <= trial_r;
        q_q <= {dvd[W-2:0], ~trial[W]};
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.mod_done) begin
        x_q <= y_q;
        y_q <= r_q;
      end
      if (cmd_i.div_step && cnt_q == CW'(1)) begin
        if (phase_q) md_q <= {q_q[W-2:0], ~trial[W]};
        else mn_q <= {q_q[W-2:0], ~trial[W]};
        phase_q <= ~phase_q;
      end
      if (cmd_i.finish) begin
        rt_q <= 1'b0;
        rn_q <= '0;
        rd_q <= '0;
        rs_q <= StOk;
        if (cmd_q > CmdDiv) begin
          case (cmd_q)
            CmdEq: rt_q <= (an_q == bn_q) && (ad_q == bd_q);
            CmdNe: rt_q <= !((an_q == bn_q) && (ad_q == bd_q));
            CmdLt: rt_q <= p0_q < p1_q;
            CmdGt: rt_q <= p0_q > p1_q;
            CmdLe: rt_q <= p0_q <= p1_q;
            CmdGe: rt_q <= p0_q >= p1_q;
            default: rt_q <= 1'b0;
          endcase
        end else if (cmd_q == CmdDiv && bn_q == 0) begin
          rs_q <= StDivZero;
        end else if (d_q == 0) begin
          rs_q <= StZeroDen;
        end else if (n_q == 0) begin
          rd_q <= 31'd1;
        end else begin
          rn_q <= neg_q ? -mn_q[31:0] : mn_q[31:0];
          rd_q <= md_q[30:0];
          if (md_q > Lim - 1 || (neg_q ? mn_q > Lim : mn_q > Lim - 1)) rs_q <= StOvf;
        end
      end
    end
  end

  assign stat_o.early = early_q;
  assign stat_o.y_zero = (y_q == 0);
  assign stat_o.cnt_zero = (cnt_q == 0);
  assign res_num_o = rn_q;
  assign res_den_o = rd_q;
  assign truth_o = rt_q;
  assign status_o = rs_q;

endmodule
`default_nettype wire

// ===== rtl/rau_ctrl.sv =====
`default_nettype none
module rau_ctrl
  import rau_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  input  wire rau_stat_t stat_i,
  output rau_cmd_t       cmd_o
);

  localparam logic [3:0] SIdle = 4'd0, SMulA = 4'd1, SMulB = 4'd2, SForm = 4'd3,
    SCheck = 4'd4, SModI = 4'd5, SMod = 4'd6, SModD = 4'd7, SDivI = 4'd8,
    SDiv = 4'd9, SFin = 4'd10, SOut = 4'd11, SDivI2 = 4'd12, SDiv2 = 4'd13;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = (state_q == SIdle);
    out_valid_o = (state_q == SOut);
    case (state_q)
      SIdle: if (in_valid_i) begin cmd_o.load = 1'b1; state_d = SMulA; end
      SMulA: begin cmd_o.mul_a = 1'b1; state_d = SMulB; end
      SMulB: begin cmd_o.mul_b = 1'b1; state_d = SForm; end
      SForm: begin cmd_o.form = 1'b1; state_d = SCheck; end
      SCheck: begin
        if (stat_i.early) state_d = SFin;
        else begin cmd_o.gcd_init = 1'b1; state_d = SModI; end
      end
      SModI: begin
        if (stat_i.y_zero) state_d = SDivI;
        else begin cmd_o.mod_init = 1'b1; state_d = SMod; end
      end
      SMod: begin
        if (stat_i.cnt_zero) begin cmd_o.mod_done = 1'b1; state_d = SModI; end
        else cmd_o.mod_step = 1'b1;
      end
      SDivI: begin cmd_o.div_init = 1'b1; state_d = SDiv; end
      SDiv: begin cmd_o.div_step = 1'b1; if (stat_i.cnt_zero) state_d = SDivI2; end
      SDivI2: begin cmd_o.div_init = 1'b1; state_d = SDiv2; end
      SDiv2: begin cmd_o.div_step = 1'b1; if (stat_i.cnt_zero) state_d = SFin; end
      SFin: begin cmd_o.finish = 1'b1; state_d = SOut; end
      SOut: if (out_ready_i) state_d = SIdle;
      default: state_d = SIdle;
    endcase
    if ((state_q == SDiv || state_q == SDiv2) && stat_i.cnt_zero) cmd_o.div_step = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SIdle;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

// ===== rtl/rau_checker.sv =====
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"
module rau_checker
  import rau_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid_i,
  input wire logic       in_ready_o,
  input wire logic       out_valid_o,
  input wire logic       out_ready_i,
  input wire logic [30:0] res_den_o,
  input wire logic       truth_o,
  input wire logic [1:0] status_o
);
  `RAU_ASSERT_IMPL(a_excl, clk_i, rst_ni, out_valid_o, !in_ready_o, "ready with pending result")
  `RAU_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "result dropped")
  `RAU_ASSERT_NEXT(a_busy, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o, "accepted twice")
  `RAU_ASSERT_IMPL(a_truth, clk_i, rst_ni, out_valid_o && truth_o, res_den_o == 0 && status_o == StOk, "truth on arithmetic")
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);
`default_nettype wire

// ===== sim/rau_scoreboard.sv =====
`timescale 1ns / 1ps
module rau_scoreboard
  import rau_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_ready_i,
  input  wire logic [3:0]  command_i,
  input  wire logic [31:0] a_num_i,
  input  wire logic [31:0] a_den_i,
  input  wire logic [31:0] b_num_i,
  input  wire logic [30:0] b_den_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_ready_i,
  input  wire logic [31:0] res_num_i,
  input  wire logic [30:0] res_den_i,
  input  wire logic        truth_i,
  input  wire logic [1:0]  status_i,
  output int               errors_o,
  output int               pending_o,
  output int               results_o
);

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic        truth;
    status_e     st;
  } frac_result_t;

  frac_result_t awaited_q[$];

  function automatic bit [63:0] gcd64(bit [63:0] x, bit [63:0] y);
    bit [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // Reduce n/d, move the sign to the numerator and flag values that do not fit.
  function automatic frac_result_t reduce_frac(longint n, longint d);
    frac_result_t r;
    bit [63:0] mn;
    bit [63:0] md;
    bit [63:0] g;
    bit [63:0] lim;
    bit [63:0] snum;
    bit neg;
    mn = (n < 0) ? 64'(-n) : 64'(n);
    md = (d < 0) ? 64'(-d) : 64'(d);
    neg = (n < 0) != (d < 0);
    r = '0;
    r.st = StOk;
    if (mn == 0) begin
      r.den = 31'd1;
      return r;
    end
    g = gcd64(mn, md);
    mn = mn / g;
    md = md / g;
    lim = 64'd1 << 31;
    if (md > lim - 1) r.st = StOvf;
    if (neg ? (mn > lim) : (mn > lim - 1)) r.st = StOvf;
    snum = neg ? -mn : mn;
    r.num = snum[31:0];
    r.den = md[30:0];
    return r;
  endfunction

  function automatic frac_result_t predict_frac(logic [3:0] cmd, logic [31:0] a_n,
                                                logic [31:0] a_d, logic [31:0] b_n,
                                                logic [30:0] b_d);
    frac_result_t r;
    longint an;
    longint ad;
    longint bn;
    longint bd;
    longint n;
    longint d;
    longint lhs;
    longint rhs;
    an = longint'(signed'(a_n));
    ad = longint'(signed'(a_d));
    bn = longint'(signed'(b_n));
    bd = longint'({33'd0, b_d});
    n = 0;
    d = 0;
    r = '0;
    r.st = StOk;
    lhs = an * bd;
    rhs = ad * bn;
    case (cmd)
      CmdNorm: begin n = an;  d = ad; end
      CmdNeg:  begin n = -an; d = ad; end
      CmdAdd:  begin n = an * bd + bn * ad; d = ad * bd; end
      CmdSub:  begin n = an * bd - bn * ad; d = ad * bd; end
      CmdMul:  begin n = an * bn; d = ad * bd; end
      CmdDiv: begin
        // A zero divisor wins over a zero denominator.
        if (bn == 0) begin
          r.st = StDivZero;
          return r;
        end
        n = an * bd;
        d = ad * bn;
      end
      CmdEq: r.truth = (an == bn) && (ad == bd);
      CmdNe: r.truth = !((an == bn) && (ad == bd));
      CmdLt: r.truth = lhs < rhs;
      CmdGt: r.truth = lhs > rhs;
      CmdLe: r.truth = lhs <= rhs;
      CmdGe: r.truth = lhs >= rhs;
      default: ;
    endcase
    if (cmd <= CmdDiv) begin
      if (d == 0) begin
        r = '0;
        r.st = StZeroDen;
        return r;
      end
      r = reduce_frac(n, d);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frac_result_t want;
    frac_result_t got;
    if (!rst_ni) begin
      errors_o  <= 0;
      results_o <= 0;
      awaited_q.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        awaited_q.push_back(predict_frac(command_i, a_num_i, a_den_i, b_num_i, b_den_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = '{res_num_i, res_den_i, truth_i, status_e'(status_i)};
        results_o <= results_o + 1;
        if (awaited_q.size() == 0) begin
          if (errors_o < 10) $display("mismatch: result beat with nothing awaited");
          errors_o <= errors_o + 1;
        end else begin
          want = awaited_q.pop_front();
          if (got != want) begin
            if (errors_o < 10) begin
              $display("mismatch: num %h/%h den %h/%h truth %b/%b status %0d/%0d (want/got)",
                       want.num, got.num, want.den, got.den, want.truth, got.truth,
                       want.st, got.st);
            end
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = awaited_q.size();

endmodule

// ===== sim/tb_rational_arithmetic_unit.sv =====
`timescale 1ns / 1ps
module tb_rational_arithmetic_unit;
  import rau_pkg::*;

  // Watchdog span: the worst gcd over 64-bit magnitudes runs about ninety
  // remainders, plus the long receiver hold, so this leaves a wide margin
  // while still catching a hung block.
  localparam int WatchdogLimit = 40000;
  localparam int RandomBeats = 1025;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [3:0]  command;
  logic [31:0] a_num;
  logic [31:0] a_den;
  logic [31:0] b_num;
  logic [30:0] b_den;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic        truth;
  logic [1:0]  status;

  int errors;
  int pending;
  int results;
  int beats_sent;
  int send_idle_pct;
  int stall_pct;
  int hold_req;
  int hold_seen;
  int hold_left;
  int quiet_cycles;

  rational_arithmetic_unit uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .command_i   (command),
    .a_num_i     (a_num),
    .a_den_i     (a_den),
    .b_num_i     (b_num),
    .b_den_i     (b_den),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .res_num_o   (res_num),
    .res_den_o   (res_den),
    .truth_o     (truth),
    .status_o    (status)
  );

  rau_scoreboard scoreboard (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .command_i   (command),
    .a_num_i     (a_num),
    .a_den_i     (a_den),
    .b_num_i     (b_num),
    .b_den_i     (b_den),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .res_num_i   (res_num),
    .res_den_i   (res_den),
    .truth_i     (truth),
    .status_i    (status),
    .errors_o    (errors),
    .pending_o   (pending),
    .results_o   (results)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // The receiver owns its stall decisions. A hold request from the stimulus
  // turns into a long run of cycles with ready low, counted here.
  initial begin
    out_ready = 1'b0;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Any accepted beat on either channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Offers one beat at a falling edge, after a random idle gap, and holds it
  // steady until the block takes it at a rising edge.
  task automatic send_beat(logic [3:0] cmd, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [30:0] bd);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    command  = cmd;
    a_num    = an;
    a_den    = ad;
    b_num    = bn;
    b_den    = bd;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  // Magnitudes are mostly small so that the gcd stays short; a tenth of the
  // values are full width so that every bit toggles.
  function automatic logic [31:0] pick_value();
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) return 32'($signed($urandom_range(510)) - 255);
    if (sel < 90) return 32'($signed($urandom_range(65534)) - 32767);
    return $urandom;
  endfunction

  // Denominators are positive most of the time, as the commands expect, but
  // zero, negative and arbitrary values still appear.
  function automatic logic [31:0] pick_den();
    int sel;
    logic [31:0] v;
    sel = $urandom_range(99);
    v = pick_value();
    if (sel < 4) return 32'd0;
    if (sel < 10) return v;
    if (v == 0) return 32'd1;
    return v[31] ? -v : v;
  endfunction

  task automatic send_random();
    logic [3:0]  cmd;
    logic [31:0] bd;
    cmd = ($urandom_range(99) < 5) ? 4'($urandom_range(15, 12)) : 4'($urandom_range(11));
    bd = pick_den();
    if ($urandom_range(99) < 5) bd = $urandom;
    send_beat(cmd, pick_value(), pick_den(), pick_value(), bd[30:0]);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    command = CmdNorm;
    a_num = '0;
    a_den = '0;
    b_num = '0;
    b_den = '0;
    beats_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    quiet_cycles = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed beats: zero denominators, sign handling, the most negative
    // value, overflow, division by zero and every comparison.
    send_beat(CmdNorm, 32'd6, 32'd0, 32'd0, 31'd1);
    send_beat(CmdNorm, 32'd6, -32'sd4, 32'd0, 31'd1);
    send_beat(CmdNorm, 32'd0, -32'sd5, 32'd0, 31'd1);
    send_beat(CmdNorm, 32'h8000_0000, 32'd1, 32'd0, 31'd1);
    send_beat(CmdNorm, 32'h7fff_ffff, 32'h8000_0000, 32'd0, 31'd1);
    send_beat(CmdNeg, 32'h8000_0000, 32'd1, 32'd0, 31'd1);
    send_beat(CmdNeg, 32'd3, 32'd7, 32'd0, 31'd1);
    send_beat(CmdAdd, 32'd1, 32'd2, 32'd1, 31'd3);
    send_beat(CmdAdd, 32'd1, 32'd0, 32'd1, 31'd3);
    send_beat(CmdAdd, 32'd1, 32'd2, 32'd1, 31'd0);
    send_beat(CmdAdd, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 31'd1);
    send_beat(CmdSub, 32'd1, 32'd2, 32'd1, 31'd2);
    send_beat(CmdSub, 32'h8000_0000, 32'd1, 32'h7fff_ffff, 31'h7fff_ffff);
    send_beat(CmdMul, 32'h8000_0000, 32'd1, 32'h8000_0000, 31'd1);
    send_beat(CmdMul, 32'd3, 32'h7fff_ffff, 32'd5, 31'h7fff_fffe);
    send_beat(CmdDiv, 32'd1, 32'd2, 32'd0, 31'd3);
    send_beat(CmdDiv, 32'd1, 32'd0, 32'd0, 31'd3);
    send_beat(CmdDiv, 32'd1, 32'd0, 32'd4, 31'd3);
    send_beat(CmdDiv, 32'd2, 32'd3, -32'sd4, 31'd5);
    send_beat(CmdEq, 32'd1, 32'd2, 32'd1, 31'd2);
    send_beat(CmdNe, 32'd1, 32'd2, 32'd2, 31'd4);
    send_beat(CmdLt, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 31'h7fff_ffff);
    send_beat(CmdGt, 32'd1, 32'd3, 32'd1, 31'd2);
    send_beat(CmdLe, 32'd2, 32'd4, 32'd1, 31'd2);
    send_beat(CmdGe, -32'sd1, 32'd2, 32'd1, 31'd2);
    send_beat(4'd15, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 31'h7fff_ffff);
    wait_drained();

    // Random beats across four idling phases. Partway through the first, the
    // receiver holds off while the sender keeps offering, so the block stalls.
    for (int i = 0; i < RandomBeats; i++) begin
      case (i * 4 / RandomBeats)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 66; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 66; end
        default: begin send_idle_pct = 15; stall_pct = 15; end
      endcase
      if (i == 40) hold_req++;
      if (i == 300 || i == 700) wait_drained();
      send_random();
    end
    wait_drained();

    repeat (200) @(posedge clk);
    $display("Covered %0d beats and %0d checked results, all commands and unused codes,",
             beats_sent, results);
    $display("under four idling mixes, a long receiver hold and drained pauses.");
    if (errors == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
sim/rau_scoreboard.sv
sim/tb_rational_arithmetic_unit.sv
